[rtl/cst_pkg.sv]
// cst_pkg: types, fixed-point constants and coefficient lookup for the taper core.
// No dependencies; used by cst_horner_cell and compact_support_distance_taper_core.
`timescale 1ns / 1ps
package cst_pkg;
	localparam int ZF = 28;
	localparam int ACC_W = 34;
	localparam int ZW = 30;
	localparam int RCP_W = 28;
	localparam int DIST_W = 24;
	localparam int HORNER_N = 5;

	typedef logic signed [ACC_W-1:0] acc_t;

	localparam acc_t K_ONE = acc_t'(64'sd268435456);
	localparam acc_t K_QUARTER = acc_t'(64'sd67108864);
	localparam acc_t K_HALF = acc_t'(64'sd134217728);
	localparam acc_t K_FIVE_EIGHTHS = acc_t'(64'sd167772160);
	localparam acc_t K_FIVE_THIRDS = acc_t'(64'sd447392427);
	localparam acc_t K_TWELFTH = acc_t'(64'sd22369621);
	localparam acc_t K_FIVE = acc_t'(64'sd1342177280);
	localparam acc_t K_FOUR = acc_t'(64'sd1073741824);
	localparam logic [RCP_W-1:0] K_TWO_THIRDS = RCP_W'(178956971);

	typedef struct packed {
		logic kill;
		logic outer;
	} zone_t;

	// additive term after each Horner product
	function automatic acc_t horner_coef(input logic [2:0] idx, input logic outer);
		acc_t c;
		c = '0;
		case (idx)
			3'd0: c = outer ? -K_HALF : K_HALF;
			3'd1: c = K_FIVE_EIGHTHS;
			3'd2: c = outer ? K_FIVE_THIRDS : -K_FIVE_THIRDS;
			3'd3: c = outer ? -K_FIVE : '0;
			3'd4: c = outer ? K_FOUR : K_ONE;
			default: c = '0;
		endcase
		return c;
	endfunction
endpackage

[rtl/cst_div_cell.sv]
// cst_div_cell: one restoring-division cell, one quotient bit per cell, registered.
// Standalone; chained by compact_support_distance_taper_core.
`timescale 1ns / 1ps
module cst_div_cell #(
	parameter int RW = 25,
	parameter int DW = 24,
	parameter int QW = 30,
	parameter int SW = 3
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] rem_i,
	input  logic          bit_i,
	input  logic [DW-1:0] div_i,
	input  logic [QW-1:0] quo_i,
	input  logic [SW-1:0] side_i,
	output logic [RW-1:0] rem_o,
	output logic [DW-1:0] div_o,
	output logic [QW-1:0] quo_o,
	output logic [SW-1:0] side_o
);
	localparam int TW = (RW + 1 > DW) ? RW + 1 : DW;
	logic [TW-1:0] trial;
	logic [TW-1:0] dext;
	logic          ge;
	logic [TW-1:0] nrem;

	always_comb begin
		trial = TW'({rem_i, bit_i});
		dext = TW'(div_i);
		ge = trial >= dext;
		nrem = ge ? trial - dext : trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= nrem[RW-1:0];
			div_o <= div_i;
			quo_o <= {quo_i[QW-2:0], ge};
			side_o <= side_i;
		end
	end
endmodule

[rtl/cst_horner_cell.sv]
// cst_horner_cell: one Horner step, acc*z rounded to Q28 (ties away from zero) plus a term.
// Depends on cst_pkg.
`timescale 1ns / 1ps
module cst_horner_cell #(
	parameter int SW = 30
) (
	input  logic                    clk,
	input  logic                    en,
	input  cst_pkg::acc_t           acc_i,
	input  cst_pkg::acc_t           coef_i,
	input  logic [cst_pkg::ZW-1:0]  z_i,
	input  logic [SW-1:0]           side_i,
	output cst_pkg::acc_t           acc_s1,
	output logic [cst_pkg::ZW-1:0]  z_s1,
	output logic [SW-1:0]           side_s1
);
	import cst_pkg::*;
	logic              neg;
	logic [ACC_W-1:0]  mag;
	logic [61:0]       prod;
	logic [61:0]       rnd;
	acc_t              p;
	acc_t              nxt;

	always_comb begin
		neg = acc_i[ACC_W-1];
		mag = neg ? ACC_W'(-acc_i) : ACC_W'(acc_i);
		prod = 62'(mag[31:0]) * 62'(z_i);
		rnd = prod + (62'(1) << (ZF - 1));
		p = acc_t'(rnd[61:ZF]);
		nxt = (neg ? -p : p) + coef_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s1 <= nxt;
			z_s1 <= z_i;
			side_s1 <= side_i;
		end
	end
endmodule

[rtl/compact_support_distance_taper_core.sv]
// compact_support_distance_taper_core: fifth-order compact taper weight per distance.
// Depends on cst_pkg, cst_div_cell, cst_horner_cell.
//
//  channel  | dir | handshake                 | payload
//  s_axis   | in  | s_tvalid / s_tready       | s_tdata[23:0] distance
//  m_axis   | out | m_tvalid / m_tready       | m_tdata[FRAC_BITS:0] weight, zero padded
//  cfg      | in  | cfg_valid / cfg_ready     | cfg_data[23:0] taper_radius
//
// One request per cycle while m_tready does not stall; stages: 30 cells for z, 28 for the reciprocal,
// 5 Horner cells, one output register.
// Reset clears valids and sets radius to 1.0. A stall at m_tready freezes the whole chain;
// s_tready follows whether the output register can move.
`timescale 1ns / 1ps
module compact_support_distance_taper_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] distance
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [((FRAC_BITS+8)/8)*8-1:0] m_tdata,  // [FRAC_BITS:0] weight
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data   // [23:0] taper_radius
);
	import cst_pkg::*;
	localparam int OUT_W = ((FRAC_BITS + 8) / 8) * 8;
	localparam int N1 = 30;
	localparam int N2 = RCP_W;
	localparam int NST = N1 + N2 + HORNER_N;
	localparam int SH = ZF - FRAC_BITS;

	logic [DIST_W-1:0] radius_q;
	logic              adv;
	logic [NST-1:0]    vld_q;
	logic              out_vld_q;
	logic [FRAC_BITS:0] weight_q;

	assign cfg_ready = 1'b1;
	assign adv = ~out_vld_q | m_tready;
	assign s_tready = adv;
	assign m_tvalid = out_vld_q;
	assign m_tdata = OUT_W'(weight_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= DIST_W'(65536);
		end else if (cfg_valid) begin
			radius_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], s_tvalid};
			out_vld_q <= vld_q[NST-1];
		end
	end

	// z = (d << 28) / r
	logic [24:0]       rem1 [0:N1];
	logic [23:0]       dv1  [0:N1];
	logic [ZW-1:0]     q1   [0:N1];
	logic [2:0]        sd1  [0:N1];
	logic              ovf;

	assign ovf = (radius_q == '0) | ({2'b00, s_tdata} >= {radius_q, 2'b00});
	assign rem1[0] = 25'(s_tdata[23:2]);
	assign dv1[0] = radius_q;
	assign q1[0] = '0;
	assign sd1[0] = {ovf, s_tdata[1:0]};

	for (genvar i = 0; i < N1; i++) begin : g_zdiv
		logic b;
		if (i == 0) begin : g_b0
			assign b = sd1[0][1];
		end else if (i == 1) begin : g_b1
			assign b = sd1[1][0];
		end else begin : g_bz
			assign b = 1'b0;
		end
		cst_div_cell #(.RW(25), .DW(24), .QW(ZW), .SW(3)) u_cell (
			.clk(clk), .en(adv),
			.rem_i(rem1[i]), .bit_i(b), .div_i(dv1[i]), .quo_i(q1[i]), .side_i(sd1[i]),
			.rem_o(rem1[i+1]), .div_o(dv1[i+1]), .quo_o(q1[i+1]), .side_o(sd1[i+1])
		);
	end

	// recip = ((2/3) << 28 + z/2) / z
	logic [ZW-1:0]    zq;
	zone_t            zone;
	logic [ZW-1:0]    rem2 [0:N2];
	logic [ZW-1:0]    dv2  [0:N2];
	logic [RCP_W-1:0] q2   [0:N2];
	logic [1:0]       sd2  [0:N2];

	assign zq = q1[N1];
	assign zone.kill = sd1[N1][2] | (zq > (ZW'(1) << (ZF + 1)));
	assign zone.outer = zq > (ZW'(1) << ZF);
	assign rem2[0] = ZW'(K_TWO_THIRDS) + ZW'(zq[ZW-1]);
	assign dv2[0] = zq;
	assign q2[0] = '0;
	assign sd2[0] = zone;

	for (genvar j = 0; j < N2; j++) begin : g_rdiv
		cst_div_cell #(.RW(ZW), .DW(ZW), .QW(RCP_W), .SW(2)) u_cell (
			.clk(clk), .en(adv),
			.rem_i(rem2[j]), .bit_i(dv2[j][RCP_W-j]), .div_i(dv2[j]), .quo_i(q2[j]),
			.side_i(sd2[j]),
			.rem_o(rem2[j+1]), .div_o(dv2[j+1]), .quo_o(q2[j+1]), .side_o(sd2[j+1])
		);
	end

	// Horner chain, polynomial chosen by zone
	acc_t                 acc [0:HORNER_N];
	logic [ZW-1:0]        zh  [0:HORNER_N];
	logic [RCP_W+1:0]     sh  [0:HORNER_N];

	assign acc[0] = sd2[N2][0] ? K_TWELFTH : -K_QUARTER;
	assign zh[0] = dv2[N2];
	assign sh[0] = {sd2[N2], q2[N2]};

	for (genvar h = 0; h < HORNER_N; h++) begin : g_horner
		cst_horner_cell #(.SW(RCP_W + 2)) u_cell (
			.clk(clk), .en(adv),
			.acc_i(acc[h]), .coef_i(horner_coef(3'(h), sh[h][RCP_W])),
			.z_i(zh[h]), .side_i(sh[h]),
			.acc_s1(acc[h+1]), .z_s1(zh[h+1]), .side_s1(sh[h+1])
		);
	end

	acc_t               g;
	logic [ZF:0]        gc;
	logic [ZF+1:0]      gr;
	logic [FRAC_BITS:0] w;

	always_comb begin
		g = acc[HORNER_N] - (sh[HORNER_N][RCP_W] ? acc_t'(sh[HORNER_N][RCP_W-1:0]) : '0);
		if (sh[HORNER_N][RCP_W+1] || g[ACC_W-1]) begin
			gc = '0;
		end else if (g > K_ONE) begin
			gc = (ZF+1)'(K_ONE);
		end else begin
			gc = g[ZF:0];
		end
		gr = (ZF+2)'(gc) + ((ZF+2)'(1) << (SH - 1));
		w = gr[ZF:SH];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			weight_q <= w;
		end
	end
endmodule
